// File: design/ipwc_pkg.sv
package ipwc_pkg;

    // Field widths of the streamed words and the configuration port.
    localparam int TICK_W     = 16;
    localparam int CNT_W      = 9;
    localparam int IDX_W      = 8;
    localparam int FUNC_W     = 2;
    localparam int STATE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;

    // Receiver output level that marks a carrier burst.
    localparam logic IR_MARK = 1'b0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd2;

    // Configuration reset values.
    localparam logic [TICK_W-1:0] GAP_RESET     = 16'd600;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd40000;
    localparam logic [CNT_W-1:0]  LENGTH_RESET  = 9'd256;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Input word kinds.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_RESTART = 2'd1,
        FUNC_READ    = 2'd2
    } func_t;

    // Capture state machine.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_MARK  = 4'b0010,
        PH_SPACE = 4'b0100,
        PH_STOP  = 4'b1000
    } phase_t;

    // Reported state codes.
    localparam logic [STATE_W-1:0] CODE_IDLE  = 2'd0;
    localparam logic [STATE_W-1:0] CODE_MARK  = 2'd1;
    localparam logic [STATE_W-1:0] CODE_SPACE = 2'd2;
    localparam logic [STATE_W-1:0] CODE_STOP  = 2'd3;

    // Result of one word, apart from the buffer read data.
    typedef struct packed {
        logic               read_hit;
        logic [CNT_W-1:0]   entry_count;
        logic [STATE_W-1:0] capture_state;
        logic               wrote_entry;
    } result_meta_t;

    function automatic logic [STATE_W-1:0] phase_code(input phase_t ph);
        logic [STATE_W-1:0] code;
        unique case (ph)
            PH_IDLE:  code = CODE_IDLE;
            PH_MARK:  code = CODE_MARK;
            PH_SPACE: code = CODE_SPACE;
            PH_STOP:  code = CODE_STOP;
            default:  code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: design/ir_pulse_width_capture.sv
// Infrared mark/space capture. Each input word is a sample tick carrying the
// receiver pin level, a capture restart, or a read of one stored duration
// (kind in s_axis_tuser). On ticks a four-state machine (idle, mark, space,
// stop) times runs of mark and space in ticks, saturating at 65535, and stores
// each finished run in an internal buffer of BUFFER_DEPTH entries. A capture
// ends on a space longer than the gap limit, on the begin timeout passing
// without a first mark, or when the configured number of entries is stored.
// Every input word yields exactly one result word with the read data (0 unless
// the read index is below the entry count), the entry count, the state code
// and a stored-this-tick flag. The block takes one word every clock cycle
// while the result stream is not stalled. The edge that accepts an input word
// updates the state, the holding stage and the buffer's registered read port,
// and the holding stage loads the output register once that register is empty
// or being taken, so the block can accept one more word while a result waits
// for m_axis_tready. The buffer is not cleared at reset, but a never-written
// entry is never returned: reads at or above the entry count give 0, and
// entries below the count are always written first. The user must see that
// configuration is written only while idle; the block does not enforce it.
module ir_pulse_width_capture #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ipwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipwc_pkg::CFG_W-1:0]         cfg_data,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: pin_level [0], read_index [8:1], zero fill [15:9]
    input  logic [ipwc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tuser: func [1:0]
    input  logic [ipwc_pkg::FUNC_W-1:0]        s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: read_data [15:0], entry_count [24:16], capture_state [26:25],
    //        wrote_entry [27], zero fill [31:28]
    output logic [ipwc_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    import ipwc_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int XW = (AW > CNT_W) ? AW : CNT_W;

    // Configuration registers.
    logic [TICK_W-1:0] gap_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic [CNT_W-1:0]  length_reg;

    // Capture state.
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CNT_W-1:0]  stored_reg, stored_next;
    phase_t            phase_reg, phase_next;

    // Duration buffer.
    logic [TICK_W-1:0] dur_mem [BUFFER_DEPTH];
    logic [TICK_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [XW-1:0]     wr_addr_x;
    logic [XW-1:0]     rd_addr_x;

    // Input word fields.
    logic              pin_level;
    logic [IDX_W-1:0]  read_index;
    logic              s_accept;

    // Per-word results.
    logic [TICK_W-1:0] tick_inc;
    logic              force_stop;
    logic              room;
    logic              store_run;
    phase_t            phase_eff;
    result_meta_t      meta;

    // Holding stage and output register.
    logic              p_valid_reg;
    result_meta_t      p_meta_reg;
    logic              p_advance;
    logic              o_valid_reg;
    logic [M_TDATA_W-1:0] o_data_reg;
    logic [TICK_W-1:0] p_read_data;

    assign pin_level  = s_axis_tdata[0];
    assign read_index = s_axis_tdata[IDX_W:1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= GAP_RESET;
            timeout_reg <= TIMEOUT_RESET;
            length_reg  <= LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAP:     gap_reg     <= cfg_data;
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_LENGTH:  length_reg  <= cfg_data[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    // The tick count saturates; the buffer is full once the count reaches the
    // configured length or the physical depth, whichever comes first.
    assign tick_inc   = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;
    assign force_stop = (stored_reg >= length_reg) ||
                        (32'(stored_reg) >= 32'(BUFFER_DEPTH));
    assign room       = 32'(stored_reg) < 32'(BUFFER_DEPTH);
    assign phase_eff  = force_stop ? PH_STOP : phase_reg;

    always_comb
    begin
        tick_next        = tick_reg;
        stored_next      = stored_reg;
        phase_next       = phase_reg;
        store_run        = 1'b0;
        mem_we           = 1'b0;
        meta.read_hit    = 1'b0;
        meta.wrote_entry = 1'b0;
        unique case (func_t'(s_axis_tuser))
            FUNC_TICK:
            begin
                tick_next  = tick_inc;
                phase_next = phase_eff;
                unique case (phase_eff)
                    PH_IDLE:
                    begin
                        if (pin_level == IR_MARK)
                        begin
                            // A mark after a long enough quiet period opens
                            // a new capture.
                            if (tick_inc >= gap_reg)
                            begin
                                stored_next = '0;
                                phase_next  = PH_MARK;
                            end
                            tick_next = '0;
                        end
                        else if (tick_inc >= timeout_reg)
                        begin
                            store_run  = 1'b1;
                            phase_next = PH_STOP;
                        end
                    end
                    PH_MARK:
                    begin
                        if (pin_level != IR_MARK)
                        begin
                            store_run  = 1'b1;
                            phase_next = PH_SPACE;
                        end
                    end
                    PH_SPACE:
                    begin
                        if (pin_level == IR_MARK)
                        begin
                            store_run  = 1'b1;
                            phase_next = PH_MARK;
                        end
                        else if (tick_inc > gap_reg)
                        begin
                            store_run  = 1'b1;
                            phase_next = PH_STOP;
                        end
                    end
                    PH_STOP:
                    begin
                        if (pin_level == IR_MARK)
                        begin
                            tick_next = '0;
                        end
                    end
                    default: ;
                endcase
                if (store_run)
                begin
                    meta.wrote_entry = 1'b1;
                    tick_next        = '0;
                    if (room)
                    begin
                        mem_we      = 1'b1;
                        stored_next = stored_reg + 1'b1;
                    end
                end
            end
            FUNC_RESTART:
            begin
                phase_next  = PH_IDLE;
                stored_next = '0;
            end
            FUNC_READ:
            begin
                meta.read_hit = (CNT_W'(read_index) < stored_reg) &&
                                (32'(read_index) < 32'(BUFFER_DEPTH));
            end
            default: ;
        endcase
        meta.entry_count   = stored_next;
        meta.capture_state = phase_code(phase_next);
    end

    // Handshake: the holding stage drains into the output register whenever
    // that register is empty or being taken.
    assign p_advance     = p_valid_reg && (!o_valid_reg || m_axis_tready);
    assign s_axis_tready = !p_valid_reg || !o_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            stored_reg <= '0;
            phase_reg  <= PH_IDLE;
        end
        else if (s_accept)
        begin
            tick_reg   <= tick_next;
            stored_reg <= stored_next;
            phase_reg  <= phase_next;
        end
    end

    assign wr_addr_x = XW'(stored_reg);
    assign rd_addr_x = XW'(read_index);

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            if (mem_we)
            begin
                dur_mem[wr_addr_x[AW-1:0]] <= tick_inc;
            end
            rd_data_reg <= dur_mem[rd_addr_x[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            p_valid_reg <= 1'b1;
        end
        else if (p_advance)
        begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p_meta_reg <= meta;
        end
    end

    assign p_read_data = p_meta_reg.read_hit ? rd_data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (p_advance)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_advance)
        begin
            o_data_reg <= {4'b0000, p_meta_reg.wrote_entry, p_meta_reg.capture_state,
                           p_meta_reg.entry_count, p_read_data};
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;

endmodule

// File: design/ipwc_checker.sv
module ipwc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [ipwc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipwc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [ipwc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [ipwc_pkg::FUNC_W-1:0]        s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [ipwc_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    import ipwc_pkg::*;

    // A stored duration always raises the entry count above zero.
    a_wrote_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[27]) |-> (m_axis_tdata[24:16] != '0))
        else $error("stored duration with zero entry count");

    // Storing a duration never leaves the machine idle.
    a_wrote_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[27]) |-> (m_axis_tdata[26:25] != CODE_IDLE))
        else $error("stored duration while reporting idle");

    // Read data and a stored duration never come from the same word.
    a_read_not_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[15:0] != '0)) |-> !m_axis_tdata[27])
        else $error("read data and store flag in one result");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

endmodule

bind ir_pulse_width_capture ipwc_checker u_ipwc_checker (.*);
